// ===== rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int DEFAULT_CAPACITY  = 16;
   localparam int VALUE_WIDTH       = 32;
   localparam int COMMAND_WIDTH     = 2;
   localparam int STATUS_WIDTH      = 2;
   localparam int COUNT_OUT_WIDTH   = 5;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_PUSH_BACK  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_BACK   = 2'd2,
      CMD_POP_FRONT  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

// ===== rtl/deq_if.sv =====
interface deq_req_if;
   logic                                  valid;
   logic                                  ready;
   deq_pkg::cmd_type                      command;
   logic signed [deq_pkg::VALUE_WIDTH-1:0] push_value;

   modport source (output valid, output command, output push_value, input ready);
   modport sink (input valid, input command, input push_value, output ready);
endinterface

interface deq_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [deq_pkg::VALUE_WIDTH-1:0]     popped_value;
   deq_pkg::status_type                       status;
   logic [deq_pkg::COUNT_OUT_WIDTH-1:0]        element_count;

   modport source (output valid, output popped_value, output status, output element_count,
                   input ready);
   modport sink (input valid, input popped_value, input status, input element_count,
                 output ready);
endinterface

// ===== rtl/double_ended_queue.sv =====
// a result is valid in the cycle after its command transaction is accepted
// throughput: one command per cycle unless the result side stalls; the slot memory has one write and one read port
// and each command uses at most one of them, so commands never interlock
// reset (synchronous, active high) empties the queue and clears the result valid;
// slot contents are not cleared and need no clearing pass
module double_ended_queue #(
   parameter int CAPACITY = deq_pkg::DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_if,
   deq_rsp_if.source  rsp_if
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             pop_ok_ff, pop_ok_in;
   deq_pkg::status_type status_ff, status_in;

   logic             req_accept;
   logic             is_full;
   logic             is_empty;
   logic [IDX_W-1:0] head_inc, head_dec, tail_inc, tail_dec;

   logic                            ram_we;
   logic [IDX_W-1:0]                ram_waddr;
   logic                            ram_re;
   logic [IDX_W-1:0]                ram_raddr;
   logic [deq_pkg::VALUE_WIDTH-1:0] ram_rdata;

   // output register parts the two sides
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   // tail points one past the back element
   assign head_inc = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? LAST_IDX : head_ff - 1'b1;
   assign tail_inc = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? LAST_IDX : tail_ff - 1'b1;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      ram_we    = 1'b0;
      ram_waddr = tail_ff;
      ram_re    = 1'b0;
      ram_raddr = head_ff;
      if (req_accept) begin
         status_in = deq_pkg::ST_OK;
         pop_ok_in = 1'b0;
         unique case (req_if.command)
            deq_pkg::CMD_PUSH_BACK: begin
               if (is_full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = tail_ff;
                  tail_in   = tail_inc;
                  count_in  = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = deq_pkg::ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = head_dec;
                  head_in   = head_dec;
                  count_in  = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_POP_BACK: begin
               if (is_empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = tail_dec;
                  tail_in   = tail_dec;
                  count_in  = count_ff - 1'b1;
                  pop_ok_in = 1'b1;
               end
            end
            deq_pkg::CMD_POP_FRONT: begin
               if (is_empty) begin
                  status_in = deq_pkg::ST_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_ff;
                  head_in   = head_inc;
                  count_in  = count_ff - 1'b1;
                  pop_ok_in = 1'b1;
               end
            end
            default: begin
               status_in = deq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pop_ok_ff    <= 1'b0;
         status_ff    <= deq_pkg::ST_OK;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         pop_ok_ff    <= pop_ok_in;
         status_ff    <= status_in;
      end
   end

   deq_ram #(
      .WIDTH (deq_pkg::VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_if.push_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // count register always holds the count after the transaction on display
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.popped_value  = pop_ok_ff ? $signed(ram_rdata) : '0;
   assign rsp_if.element_count = deq_pkg::COUNT_OUT_WIDTH'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("element count above capacity");

   a_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with count");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_full &&
       (req_if.command == deq_pkg::CMD_PUSH_BACK || req_if.command == deq_pkg::CMD_PUSH_FRONT))
      |=> (rsp_if.valid && rsp_if.status == deq_pkg::ST_FULL && $stable(count_ff)))
      else $error("push on full not flagged or not dropped");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == deq_pkg::ST_EMPTY) |-> (!pop_ok_ff && count_ff == '0))
      else $error("empty pop reported with data");

   a_pop_reads: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_empty &&
       (req_if.command == deq_pkg::CMD_POP_BACK || req_if.command == deq_pkg::CMD_POP_FRONT))
      |-> (ram_re && !ram_we))
      else $error("pop did not read the slot memory");

endmodule

// ===== rtl/deq_ram.sv =====
module deq_ram #(
   parameter int WIDTH = deq_pkg::VALUE_WIDTH,
   parameter int DEPTH = deq_pkg::DEFAULT_CAPACITY
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
